>>> design/hkrb_pkg.sv
package hkrb_pkg;

	localparam int NUM_SLOTS_DEF = 6;
	localparam int SHOWN_SLOTS = 6;
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

	localparam logic [2:0] CMD_PRESS_KEY = 3'd0;
	localparam logic [2:0] CMD_RELEASE_KEY = 3'd1;
	localparam logic [2:0] CMD_PRESS_RAW = 3'd2;
	localparam logic [2:0] CMD_RELEASE_RAW = 3'd3;
	localparam logic [2:0] CMD_PRESS_MODS = 3'd4;
	localparam logic [2:0] CMD_RELEASE_MODS = 3'd5;
	localparam logic [2:0] CMD_RELEASE_ALL = 3'd6;

	localparam logic [7:0] KEY_OFFSET = 8'd136;
	localparam logic [7:0] MOD_KEY_BASE = 8'd128;
	localparam logic [7:0] LEFT_SHIFT = 8'h02;
	localparam logic [7:0] USAGE_MASK = 8'h7F;
	localparam int ROM_SHIFT_BIT = 7;

	localparam logic [7:0] ASCII_ROM [128] = '{
		8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
		8'h2a, 8'h2b, 8'h28, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
		8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
		8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
		8'h2c, 8'h9e, 8'hb4, 8'ha0, 8'ha1, 8'ha2, 8'ha4, 8'h34,
		8'ha6, 8'ha7, 8'ha5, 8'hae, 8'h36, 8'h2d, 8'h37, 8'h38,
		8'h27, 8'h1e, 8'h1f, 8'h20, 8'h21, 8'h22, 8'h23, 8'h24,
		8'h25, 8'h26, 8'hb3, 8'h33, 8'hb6, 8'h2e, 8'hb7, 8'hb8,
		8'h9f, 8'h84, 8'h85, 8'h86, 8'h87, 8'h88, 8'h89, 8'h8a,
		8'h8b, 8'h8c, 8'h8d, 8'h8e, 8'h8f, 8'h90, 8'h91, 8'h92,
		8'h93, 8'h94, 8'h95, 8'h96, 8'h97, 8'h98, 8'h99, 8'h9a,
		8'h9b, 8'h9c, 8'h9d, 8'h2f, 8'h31, 8'h30, 8'ha3, 8'had,
		8'h35, 8'h04, 8'h05, 8'h06, 8'h07, 8'h08, 8'h09, 8'h0a,
		8'h0b, 8'h0c, 8'h0d, 8'h0e, 8'h0f, 8'h10, 8'h11, 8'h12,
		8'h13, 8'h14, 8'h15, 8'h16, 8'h17, 8'h18, 8'h19, 8'h1a,
		8'h1b, 8'h1c, 8'h1d, 8'haf, 8'hb1, 8'hb0, 8'hb5, 8'h00
	};

	typedef enum logic [2:0] {
		OPK_NOP,
		OPK_INSERT,
		OPK_REMOVE,
		OPK_MODS,
		OPK_CLEAR
	} op_kind_t;

	typedef struct packed {
		logic [2:0] cmd;
		logic [7:0] key_code;
	} req_t;

	typedef struct packed {
		op_kind_t   kind;
		logic [7:0] usage;
		logic [7:0] mod_set;
		logic [7:0] mod_clr;
		logic       set_err;
	} op_t;

	typedef struct packed {
		logic [7:0] modifier_bits;
		logic [7:0] slot_zero;
		logic [7:0] slot_one;
		logic [7:0] slot_two;
		logic [7:0] slot_three;
		logic [7:0] slot_four;
		logic [7:0] slot_five;
		logic       report_sent;
		logic       accepted;
		logic       error_flag;
	} res_t;

endpackage

>>> design/hkrb_front.sv
module hkrb_front (
	input  hkrb_pkg::req_t req,
	output hkrb_pkg::op_t  op
);

	logic [7:0] rom_q;
	logic [7:0] mod_bit;
	logic       press;

	assign rom_q = hkrb_pkg::ASCII_ROM[req.key_code[6:0]];
	assign mod_bit = 8'd1 << req.key_code[2:0];
	assign press = (req.cmd == hkrb_pkg::CMD_PRESS_KEY);

	always_comb begin
		op.kind = hkrb_pkg::OPK_NOP;
		op.usage = 8'd0;
		op.mod_set = 8'd0;
		op.mod_clr = 8'd0;
		op.set_err = 1'b0;
		case (req.cmd)
			hkrb_pkg::CMD_PRESS_KEY, hkrb_pkg::CMD_RELEASE_KEY: begin
				op.kind = press ? hkrb_pkg::OPK_INSERT : hkrb_pkg::OPK_REMOVE;
				if (req.key_code >= hkrb_pkg::KEY_OFFSET) begin
					op.usage = req.key_code - hkrb_pkg::KEY_OFFSET;
				end else if (req.key_code >= hkrb_pkg::MOD_KEY_BASE) begin
					// modifier key: bit change, then acts on usage zero
					if (press) op.mod_set = mod_bit;
					else op.mod_clr = mod_bit;
				end else if (rom_q == 8'd0) begin
					op.kind = hkrb_pkg::OPK_NOP;
					op.set_err = press;
				end else begin
					if (rom_q[hkrb_pkg::ROM_SHIFT_BIT]) begin
						if (press) op.mod_set = hkrb_pkg::LEFT_SHIFT;
						else op.mod_clr = hkrb_pkg::LEFT_SHIFT;
					end
					op.usage = rom_q & hkrb_pkg::USAGE_MASK;
				end
			end
			hkrb_pkg::CMD_PRESS_RAW: begin
				op.kind = hkrb_pkg::OPK_INSERT;
				op.usage = req.key_code;
			end
			hkrb_pkg::CMD_RELEASE_RAW: begin
				op.kind = hkrb_pkg::OPK_REMOVE;
				op.usage = req.key_code;
			end
			hkrb_pkg::CMD_PRESS_MODS: begin
				op.kind = hkrb_pkg::OPK_MODS;
				op.mod_set = req.key_code;
			end
			hkrb_pkg::CMD_RELEASE_MODS: begin
				op.kind = hkrb_pkg::OPK_MODS;
				op.mod_clr = req.key_code;
			end
			hkrb_pkg::CMD_RELEASE_ALL: begin
				op.kind = hkrb_pkg::OPK_CLEAR;
			end
			default: begin
				op.kind = hkrb_pkg::OPK_NOP;
			end
		endcase
	end

endmodule

>>> design/hkrb_queue.sv
module hkrb_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  hkrb_pkg::op_t push_op,
	input  logic          pop,
	output hkrb_pkg::op_t head_op,
	output logic          not_empty,
	output logic          full
);

	hkrb_pkg::op_t                 entry_q [hkrb_pkg::QUEUE_DEPTH];
	logic [hkrb_pkg::QPTR_W-1:0]   wr_ptr_q;
	logic [hkrb_pkg::QPTR_W-1:0]   rd_ptr_q;
	logic [hkrb_pkg::QCNT_W-1:0]   count_q;
	logic                          do_push;
	logic                          do_pop;

	assign not_empty = (count_q != '0);
	assign full = (count_q == hkrb_pkg::QCNT_W'(hkrb_pkg::QUEUE_DEPTH));
	assign do_push = push && !full;
	assign do_pop = pop && not_empty;
	assign head_op = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) entry_q[wr_ptr_q] <= push_op;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				if (wr_ptr_q == hkrb_pkg::QPTR_W'(hkrb_pkg::QUEUE_DEPTH - 1)) wr_ptr_q <= '0;
				else wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				if (rd_ptr_q == hkrb_pkg::QPTR_W'(hkrb_pkg::QUEUE_DEPTH - 1)) rd_ptr_q <= '0;
				else rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10: count_q <= count_q + 1'b1;
				2'b01: count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

>>> design/hkrb_back.sv
module hkrb_back #(
	parameter int NUM_SLOTS = hkrb_pkg::NUM_SLOTS_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           op_valid,
	input  hkrb_pkg::op_t  op,
	output logic           done,
	output hkrb_pkg::res_t result
);

	logic [7:0]           slots_q [NUM_SLOTS];
	logic [7:0]           mod_q;
	logic                 err_q;
	logic                 done_q;
	hkrb_pkg::res_t       result_q;

	logic [NUM_SLOTS-1:0] match;
	logic [NUM_SLOTS-1:0] empty;
	logic [NUM_SLOTS-1:0] first_empty;
	logic [7:0]           slots_nx [NUM_SLOTS];
	logic [7:0]           mod_nx;
	logic                 err_nx;
	logic                 ok;
	logic [7:0]           shown [hkrb_pkg::SHOWN_SLOTS];

	always_comb begin
		for (int i = 0; i < NUM_SLOTS; i++) begin
			match[i] = (slots_q[i] == op.usage);
			empty[i] = (slots_q[i] == 8'd0);
		end
	end

	// isolate the lowest empty slot
	assign first_empty = empty & (~empty + 1'b1);

	always_comb begin
		slots_nx = slots_q;
		mod_nx = (mod_q & ~op.mod_clr) | op.mod_set;
		err_nx = err_q;
		ok = 1'b0;
		case (op.kind)
			hkrb_pkg::OPK_INSERT: begin
				// usage zero matches any empty slot, so it succeeds unless all are full
				if (|match) begin
					ok = 1'b1;
				end else if (|empty) begin
					ok = 1'b1;
					for (int i = 0; i < NUM_SLOTS; i++)
						if (first_empty[i]) slots_nx[i] = op.usage;
				end else begin
					err_nx = 1'b1;
				end
			end
			hkrb_pkg::OPK_REMOVE: begin
				ok = 1'b1;
				if (op.usage != 8'd0) begin
					for (int i = 0; i < NUM_SLOTS; i++)
						if (match[i]) slots_nx[i] = 8'd0;
				end
			end
			hkrb_pkg::OPK_MODS: begin
				ok = 1'b1;
			end
			hkrb_pkg::OPK_CLEAR: begin
				ok = 1'b1;
				mod_nx = 8'd0;
				for (int i = 0; i < NUM_SLOTS; i++) slots_nx[i] = 8'd0;
			end
			default: begin
				err_nx = err_q | op.set_err;
			end
		endcase
	end

	for (genvar g = 0; g < hkrb_pkg::SHOWN_SLOTS; g++) begin : g_shown
		if (g < NUM_SLOTS) begin : g_real
			assign shown[g] = slots_nx[g];
		end else begin : g_pad
			assign shown[g] = 8'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_SLOTS; i++) slots_q[i] <= 8'd0;
			mod_q <= 8'd0;
			err_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= op_valid;
			if (op_valid) begin
				slots_q <= slots_nx;
				mod_q <= mod_nx;
				err_q <= err_nx;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (op_valid) begin
			result_q.modifier_bits <= mod_nx;
			result_q.slot_zero <= shown[0];
			result_q.slot_one <= shown[1];
			result_q.slot_two <= shown[2];
			result_q.slot_three <= shown[3];
			result_q.slot_four <= shown[4];
			result_q.slot_five <= shown[5];
			result_q.report_sent <= ok;
			result_q.accepted <= ok;
			result_q.error_flag <= err_nx;
		end
	end

	assign done = done_q;
	assign result = result_q;

endmodule

>>> design/hid_keyboard_report_builder.sv
// Keyboard boot report keeper. One request per cycle: a request taken on start (busy low)
// is decoded by the front end, waits in a two-entry queue, and is applied to the slot
// registers by the back end, which retires one entry every cycle. The queue registers the
// request on acceptance, and the back end then registers its result, with done marking
// that result; the receiver cannot stall it. Since the back end never stalls, the queue
// holds at most one entry and busy stays low.
module hid_keyboard_report_builder #(
	parameter int NUM_SLOTS = hkrb_pkg::NUM_SLOTS_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	output logic           busy,
	input  hkrb_pkg::req_t req,
	output logic           done,
	output hkrb_pkg::res_t result
);

	hkrb_pkg::op_t front_op;
	hkrb_pkg::op_t head_op;
	logic          q_not_empty;
	logic          q_full;

	hkrb_front u_front (
		.req (req),
		.op  (front_op)
	);

	hkrb_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (start),
		.push_op   (front_op),
		.pop       (1'b1),
		.head_op   (head_op),
		.not_empty (q_not_empty),
		.full      (q_full)
	);

	hkrb_back #(
		.NUM_SLOTS (NUM_SLOTS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.op_valid (q_not_empty),
		.op       (head_op),
		.done     (done),
		.result   (result)
	);

	assign busy = q_full;

	a_req_to_result: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##2 done)
		else $error("request did not produce a result");

	a_sent_is_accepted: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (result.report_sent == result.accepted))
		else $error("report_sent and accepted disagree");

	a_error_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.error_flag) ##1 done |-> result.error_flag)
		else $error("sticky error cleared");

	a_no_idle_result: assert property (@(posedge clk) disable iff (!arst_n)
		!(start && !busy) ##1 !q_not_empty |=> !done)
		else $error("result without a request");

endmodule
